@@ rtl/core/hll_pkg.sv @@
// ----------------------------------------------------------------------------
// hll_pkg
// Shared types, codes and constants of the HyperLogLog register update block.
// ----------------------------------------------------------------------------
package hll_pkg;

    localparam int INDEX_BITS_DEF = 10;

    // Register value width and fixed-point format of the harmonic sum
    localparam int REG_W     = 7;
    localparam int FRAC_BITS = 48;
    localparam int SUM_W     = 59;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Stream payload layout
    localparam int KIND_W    = 3;
    localparam int ELEM_W    = 64;
    localparam int IDX_FLD_W = 10;
    localparam int S_DATA_W  = 88;   // 64 + 10 + 7 = 81, padded to bytes
    localparam int M_DATA_W  = 72;   // 7 + 59 = 66, padded to bytes

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [REG_W-1:0]  reg_val_t;
    typedef logic [ELEM_W-1:0] word_t;

    localparam kind_t KIND_ADD   = 3'd0;
    localparam kind_t KIND_MERGE = 3'd1;
    localparam kind_t KIND_READ  = 3'd2;
    localparam kind_t KIND_SUM   = 3'd3;
    localparam kind_t KIND_CLEAR = 3'd4;

    localparam logic RES_READ = 1'b0;
    localparam logic RES_SUM  = 1'b1;

    // Jenkins-style 64-bit mix: fixed seed and golden-ratio start value
    localparam word_t HASH_SEED   = 64'h9fba92b0fa0ce343;
    localparam word_t GOLDEN_INIT = 64'h9e3779b97f4a7c13;

    localparam int MIX_STEPS  = 12;
    localparam int MIX_STEP_W = 4;

    // Per-step shift: bit 6 set means left shift, bits 5:0 the amount
    typedef logic [6:0] mix_shift_t;
    localparam int MIX_LEFT = 6;
    localparam mix_shift_t MIX_SHIFT [MIX_STEPS] = '{
        7'd43, 7'd64 + 7'd9,  7'd8,
        7'd38, 7'd64 + 7'd23, 7'd5,
        7'd35, 7'd64 + 7'd49, 7'd11,
        7'd12, 7'd64 + 7'd18, 7'd22
    };

endpackage

@@ rtl/core/hll_hash.sv @@
// ----------------------------------------------------------------------------
// hll_hash
// Iterative 64-bit mixer: one subtract/subtract/xor-shift step per cycle.
// ----------------------------------------------------------------------------
module hll_hash
    import hll_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t value,
    output logic  done,
    output word_t hash
);

    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_C = 2'd2;
    localparam logic [MIX_STEP_W-1:0] LAST_STEP = MIX_STEP_W'(MIX_STEPS - 1);

    word_t a_reg, b_reg, c_reg;
    logic [MIX_STEP_W-1:0] step_reg;
    logic [1:0] phase_reg;
    logic busy_reg, done_reg;

    word_t x, y, z, shz, nx;
    mix_shift_t sh;

    // Target rotates a, b, c; new x = (x - y - z) ^ shift(z)
    always_comb
    begin
        unique case (phase_reg)
            PH_A:
            begin
                x = a_reg; y = b_reg; z = c_reg;
            end
            PH_B:
            begin
                x = b_reg; y = c_reg; z = a_reg;
            end
            PH_C:
            begin
                x = c_reg; y = a_reg; z = b_reg;
            end
            default:
            begin
                x = c_reg; y = a_reg; z = b_reg;
            end
        endcase
        sh  = MIX_SHIFT[step_reg];
        shz = sh[MIX_LEFT] ? (z << sh[5:0]) : (z >> sh[5:0]);
        nx  = (x - y - z) ^ shz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            step_reg  <= '0;
            phase_reg <= PH_A;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                step_reg  <= '0;
                phase_reg <= PH_A;
            end
            else if (busy_reg)
            begin
                step_reg  <= step_reg + 1'b1;
                phase_reg <= (phase_reg == PH_C) ? PH_A : phase_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= HASH_SEED + value;
            b_reg <= HASH_SEED;
            c_reg <= GOLDEN_INIT;
        end
        else if (busy_reg)
        begin
            unique case (phase_reg)
                PH_A:    a_reg <= nx;
                PH_B:    b_reg <= nx;
                default: c_reg <= nx;
            endcase
        end
    end

    assign done = done_reg;
    assign hash = c_reg;

endmodule

@@ rtl/core/hll_regfile.sv @@
// ----------------------------------------------------------------------------
// hll_regfile
// Sketch register memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hll_regfile
    import hll_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [INDEX_BITS-1:0] wr_addr,
    input  reg_val_t              wr_data,
    input  logic                  rd_en,
    input  logic [INDEX_BITS-1:0] rd_addr,
    output reg_val_t              rd_data
);

    reg_val_t mem [2**INDEX_BITS];
    reg_val_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/hyperloglog_register_update.sv @@
// Add runs 12 hash steps, then a read-modify-write; merge is the read-modify-write alone; clear zeroes each register.
// Read goes through a memory read, then the output register; sum walks every register, then the output register.
// One item is in flight at a time; the sketch memory's single read port sets sum length.
// A finished result waits in the output register while the next item is accepted.
// After reset a clearing pass zeroes every register of the memory; s_tready stays low.
// ----------------------------------------------------------------------------
// hyperloglog_register_update
// HyperLogLog sketch: add, merge, read, harmonic sum and clear over 2^B registers.
// ----------------------------------------------------------------------------
module hyperloglog_register_update
    import hll_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // element_value, register_index, merge_value
    input  logic [KIND_W-1:0]   s_tuser,   // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // register_value, harmonic_sum
    output logic                m_tuser    // result_kind
);

    localparam int LOW_W = 64 - INDEX_BITS;
    localparam int ACC_W = (INDEX_BITS + 49 > SUM_W) ? INDEX_BITS + 49 : SUM_W;
    localparam logic [INDEX_BITS-1:0] LAST_ADDR = '1;

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_HASH     = 4'd2;
    localparam logic [3:0] ST_RMW_RD   = 4'd3;
    localparam logic [3:0] ST_RMW_WR   = 4'd4;
    localparam logic [3:0] ST_READ_RD  = 4'd5;
    localparam logic [3:0] ST_SUM      = 4'd6;
    localparam logic [3:0] ST_SUM_LAST = 4'd7;
    localparam logic [3:0] ST_OUT      = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [INDEX_BITS-1:0] cnt_reg, cnt_next;
    logic [INDEX_BITS-1:0] addr_reg, addr_next;
    reg_val_t val_reg, val_next;
    logic res_kind_reg, res_kind_next;
    logic pend_reg, pend_next;
    logic [ACC_W-1:0] acc_reg, acc_next;

    logic m_tvalid_reg;
    logic m_tuser_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    // Input fields
    kind_t                 in_kind;
    word_t                 in_elem;
    logic [INDEX_BITS-1:0] in_idx;
    reg_val_t              in_merge;
    logic                  in_fire;

    assign in_kind  = s_tuser;
    assign in_elem  = s_tdata[63:0];
    assign in_idx   = INDEX_BITS'(s_tdata[73:64]);
    assign in_merge = s_tdata[80:74];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    // Hash unit
    logic  hash_start, hash_done;
    word_t hash;

    assign hash_start = in_fire && (in_kind == KIND_ADD);

    hll_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .value (in_elem),
        .done  (hash_done),
        .hash  (hash)
    );

    // Rho: trailing zeros plus one of the low bits, 64 when they are zero
    reg_val_t rank;
    always_comb
    begin
        rank = reg_val_t'(64);
        for (int i = LOW_W - 1; i >= 0; i--)
        begin
            if (hash[i])
            begin
                rank = reg_val_t'(i + 1);
            end
        end
    end

    // Sketch memory
    logic                  wr_en, rd_en;
    logic [INDEX_BITS-1:0] wr_addr, rd_addr;
    reg_val_t              wr_data, rd_data;

    hll_regfile #(
        .INDEX_BITS (INDEX_BITS)
    ) u_regfile (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Harmonic term 2^(48-r), truncated to zero for r above 48
    logic [ACC_W-1:0] term;
    logic [5:0] term_sh;
    always_comb
    begin
        term_sh = 6'(FRAC_BITS) - rd_data[5:0];
        if (rd_data <= reg_val_t'(FRAC_BITS))
        begin
            term = ACC_W'(1) << term_sh;
        end
        else
        begin
            term = '0;
        end
    end

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        addr_next     = addr_reg;
        val_next      = val_reg;
        res_kind_next = res_kind_reg;
        pend_next     = 1'b0;
        acc_next      = acc_reg;
        wr_en         = 1'b0;
        wr_addr       = addr_reg;
        wr_data       = val_reg;
        rd_en         = 1'b0;
        rd_addr       = addr_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg;
                wr_data  = '0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    addr_next = in_idx;
                    val_next  = in_merge;
                    cnt_next  = '0;
                    acc_next  = '0;
                    unique case (in_kind)
                        KIND_ADD:   state_next = ST_HASH;
                        KIND_MERGE: state_next = ST_RMW_RD;
                        KIND_READ:
                        begin
                            res_kind_next = RES_READ;
                            state_next    = ST_READ_RD;
                        end
                        KIND_SUM:
                        begin
                            res_kind_next = RES_SUM;
                            state_next    = ST_SUM;
                        end
                        KIND_CLEAR: state_next = ST_CLEAR;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    addr_next  = hash[63 -: INDEX_BITS];
                    val_next   = rank;
                    state_next = ST_RMW_RD;
                end
            end
            ST_RMW_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_RMW_WR;
            end
            ST_RMW_WR:
            begin
                wr_en      = (val_reg > rd_data);
                state_next = ST_IDLE;
            end
            ST_READ_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_OUT;
            end
            ST_SUM:
            begin
                rd_en     = 1'b1;
                rd_addr   = cnt_reg;
                pend_next = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (pend_reg)
                begin
                    acc_next = acc_reg + term;
                end
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_SUM_LAST;
                end
            end
            ST_SUM_LAST:
            begin
                acc_next   = acc_reg + term;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        val_reg      <= val_next;
        res_kind_reg <= res_kind_next;
        acc_reg      <= acc_next;
    end

    // Output register
    logic [SUM_W-1:0] sum_sat;
    assign sum_sat = (acc_reg > ACC_W'(SUM_MAX)) ? SUM_MAX : acc_reg[SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (state_reg == ST_OUT && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            m_tuser_reg <= res_kind_reg;
            if (res_kind_reg == RES_SUM)
            begin
                m_tdata_reg <= M_DATA_W'({sum_sat, reg_val_t'(0)});
            end
            else
            begin
                m_tdata_reg <= M_DATA_W'({{SUM_W{1'b0}}, rd_data});
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for hyperloglog_register_update. A local predictor keeps
// its own copy of the sketch, hashes every add element and queues the read and
// sum results that each accepted transaction should produce; a checker pops
// the queue on every accepted output transaction. Directed corners first, then
// randomized sketch sessions with random idle on both stream sides.
// ----------------------------------------------------------------------------
module testbench;
    import hll_pkg::*;

    localparam int IDX_BITS     = 10;
    localparam int REG_TOTAL    = 1 << IDX_BITS;
    localparam int RANDOM_ITEMS = 1900;
    // longest busy stretch is a sum or clear walk over all registers
    localparam int SETTLE_CYCLES = REG_TOTAL + 64;
    localparam int IDLE_LIMIT    = 20000;

    localparam logic [63:0] MIX_SEED   = 64'h9fba92b0fa0ce343;
    localparam logic [63:0] MIX_GOLDEN = 64'h9e3779b97f4a7c13;
    localparam logic [63:0] SUM_CEIL   = (64'd1 << SUM_W) - 64'd1;
    localparam kind_t       KIND_TOP   = '1;

    typedef struct packed {
        logic             is_sum;
        reg_val_t         reg_val;
        logic [SUM_W-1:0] hsum;
    } sketch_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;   // element_value, register_index, merge_value
    logic [KIND_W-1:0]   s_tuser = '0;   // kind
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // register_value, harmonic_sum
    logic                m_tuser;        // result_kind

    reg_val_t       sketch_model [REG_TOTAL];
    sketch_result_t pending_results [$];
    int             error_count = 0;
    int             items_sent = 0;
    int             idle_cycles = 0;
    bit             tx_fast = 1'b0;
    bit             rx_fast = 1'b0;

    hyperloglog_register_update #(
        .INDEX_BITS (IDX_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] mix_element(input logic [63:0] v);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        a = MIX_SEED + v;
        b = MIX_SEED;
        c = MIX_GOLDEN;
        a = a - b - c; a = a ^ (c >> 43);
        b = b - c - a; b = b ^ (a << 9);
        c = c - a - b; c = c ^ (b >> 8);
        a = a - b - c; a = a ^ (c >> 38);
        b = b - c - a; b = b ^ (a << 23);
        c = c - a - b; c = c ^ (b >> 5);
        a = a - b - c; a = a ^ (c >> 35);
        b = b - c - a; b = b ^ (a << 49);
        c = c - a - b; c = c ^ (b >> 11);
        a = a - b - c; a = a ^ (c >> 12);
        b = b - c - a; b = b ^ (a << 18);
        c = c - a - b; c = c ^ (b >> 22);
        return c;
    endfunction

    // trailing zeros + 1 of the bits below the register index, 64 when all zero
    function automatic reg_val_t rank_of(input logic [63:0] h);
        logic [63-IDX_BITS:0] low;
        reg_val_t             n;
        low = h[63-IDX_BITS:0];
        if (low == '0)
            return 7'd64;
        n = 7'd1;
        while (!low[0])
        begin
            low = low >> 1;
            n++;
        end
        return n;
    endfunction

    function automatic logic [SUM_W-1:0] harmonic_total();
        logic [63:0] acc;
        acc = '0;
        for (int i = 0; i < REG_TOTAL; i++)
        begin
            if (sketch_model[i] <= FRAC_BITS)
                acc += 64'd1 << (FRAC_BITS - sketch_model[i]);
        end
        if (acc > SUM_CEIL)
            acc = SUM_CEIL;
        return acc[SUM_W-1:0];
    endfunction

    function automatic void update_sketch(input kind_t kind, input logic [63:0] elem,
                                          input logic [IDX_FLD_W-1:0] idx,
                                          input reg_val_t mv);
        logic [63:0]         h;
        logic [IDX_BITS-1:0] slot;
        reg_val_t            r;
        sketch_result_t      res;
        slot = idx[IDX_BITS-1:0];
        res  = '0;
        case (kind)
            KIND_ADD:
            begin
                h    = mix_element(elem);
                slot = h[63 -: IDX_BITS];
                r    = rank_of(h);
                if (r > sketch_model[slot])
                    sketch_model[slot] = r;
            end
            KIND_MERGE:
            begin
                if (mv > sketch_model[slot])
                    sketch_model[slot] = mv;
            end
            KIND_READ:
            begin
                res.is_sum  = RES_READ;
                res.reg_val = sketch_model[slot];
                pending_results.push_back(res);
            end
            KIND_SUM:
            begin
                res.is_sum = RES_SUM;
                res.hsum   = harmonic_total();
                pending_results.push_back(res);
            end
            KIND_CLEAR:
            begin
                foreach (sketch_model[i])
                    sketch_model[i] = '0;
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_item(input kind_t kind, input logic [63:0] elem,
                             input logic [IDX_FLD_W-1:0] idx, input reg_val_t mv);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tuser  <= kind;
        s_tdata  <= {{(S_DATA_W - ELEM_W - IDX_FLD_W - REG_W){1'b0}}, mv, idx, elem};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        update_sketch(kind, elem, idx, mv);
        items_sent++;
    endtask

    task automatic send_random_fields(input kind_t kind);
        send_item(kind, {$urandom, $urandom}, IDX_FLD_W'($urandom_range(0, REG_TOTAL - 1)),
                  reg_val_t'($urandom_range(0, 127)));
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_corners();
        tx_fast = 1'b0;
        send_item(KIND_SUM, '0, '0, '0);            // empty sketch sums to m
        send_item(KIND_READ, '0, '0, '0);
        send_item(KIND_READ, '0, '1, '0);
        send_item(KIND_MERGE, '0, 10'd0, 7'd127);   // above 64 is stored as is
        send_item(KIND_MERGE, '0, 10'd1023, 7'd64);
        send_item(KIND_MERGE, '0, 10'd512, 7'd48);  // smallest term kept
        send_item(KIND_MERGE, '0, 10'd511, 7'd49);  // first term truncated
        send_item(KIND_MERGE, '0, 10'd0, 7'd0);
        send_item(KIND_MERGE, '0, 10'd512, 7'd1);   // smaller value, no change
        send_item(KIND_READ, '0, 10'd0, '0);
        send_item(KIND_READ, '0, 10'd1023, '0);
        send_item(KIND_READ, '0, 10'd512, '0);
        send_item(KIND_READ, '0, 10'd511, '0);
        send_item(KIND_ADD, 64'd0, '0, '0);
        send_item(KIND_ADD, '1, '0, '0);
        send_item(KIND_ADD, 64'h8000_0000_0000_0000, '1, '1);
        send_item(KIND_ADD, 64'd1, '0, '0);
        for (int k = KIND_CLEAR + 1; k <= KIND_TOP; k++)
            send_random_fields(kind_t'(k));         // unused kinds: no effect
        send_item(KIND_SUM, '0, '0, '0);
        send_item(KIND_CLEAR, '0, '0, '0);
        send_item(KIND_READ, '0, 10'd0, '0);
        send_item(KIND_SUM, '0, '0, '0);
    endtask

    // one sketch session: optional clear, a stream of adds mixed with other
    // kinds, then a sum and a few reads
    task automatic run_sketch_session(input int n_items);
        int pick;
        tx_fast = ($urandom_range(0, 3) == 0);
        rx_fast = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) == 0)
            send_item(KIND_CLEAR, {$urandom, $urandom}, '0, '0);
        for (int n = 0; n < n_items; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                send_random_fields(KIND_ADD);
            else if (pick < 77)
                send_item(KIND_MERGE, {$urandom, $urandom},
                          IDX_FLD_W'($urandom_range(0, REG_TOTAL - 1)),
                          ($urandom_range(0, 3) == 0) ? reg_val_t'($urandom_range(0, 127))
                                                      : reg_val_t'($urandom_range(0, 24)));
            else if (pick < 92)
                send_random_fields(KIND_READ);
            else if (pick < 94)
                send_random_fields(KIND_SUM);
            else if (pick < 95)
                send_random_fields(KIND_CLEAR);
            else
                send_random_fields(kind_t'($urandom_range(KIND_CLEAR + 1, KIND_TOP)));
        end
        send_random_fields(KIND_SUM);
        repeat (4) send_random_fields(KIND_READ);
    endtask

    task automatic test_random_sessions(input int n_total);
        int start;
        start = items_sent;
        while (items_sent - start < n_total)
            run_sketch_session($urandom_range(20, 80));
    endtask

    // sender holds off until the result stream is empty, then resumes
    task automatic test_drain_pause();
        wait_results_drained();
        run_sketch_session(40);
    endtask

    initial
    begin : stimulus
        foreach (sketch_model[i])
            sketch_model[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_random_sessions(RANDOM_ITEMS / 2);
        test_drain_pause();
        test_random_sessions(RANDOM_ITEMS / 2);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : result_ready
        int stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = rx_fast ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin : check_results
        sketch_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected transaction, expected none, actual kind %0d data %h",
                         $time, m_tuser, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.is_sum)
                begin
                    error_count++;
                    $display("%0t: result_kind mismatch, expected %0d actual %0d",
                             $time, want.is_sum, m_tuser);
                end
                if (m_tdata[REG_W-1:0] !== want.reg_val)
                begin
                    error_count++;
                    $display("%0t: register_value mismatch, expected %0d actual %0d",
                             $time, want.reg_val, m_tdata[REG_W-1:0]);
                end
                if (m_tdata[REG_W+SUM_W-1:REG_W] !== want.hsum)
                begin
                    error_count++;
                    $display("%0t: harmonic_sum mismatch, expected %h actual %h",
                             $time, want.hsum, m_tdata[REG_W+SUM_W-1:REG_W]);
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: timeout, no transaction for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
rtl/core/hll_pkg.sv
rtl/core/hll_hash.sv
rtl/core/hll_regfile.sv
rtl/core/hyperloglog_register_update.sv
bench/testbench.sv
